// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ESM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ESM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/esm_pkg.sv =====
package esm_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int KEY_COUNT       = 16;
  localparam int MAX_RESULTS     = 32;
  localparam int HIT_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] KIND_SUB   = 2'd0;
  localparam logic [1:0] KIND_UNSUB = 2'd1;
  localparam logic [1:0] KIND_PUB   = 2'd2;
  localparam logic [1:0] KIND_CLR   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NULL      = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DELIVERY  = 3'd5;

  typedef struct packed {
    logic [3:0]  key;
    logic [31:0] mask;
    logic [31:0] callback;
    logic [31:0] context_w;
  } esm_entry_t;

  typedef struct packed {
    logic cap_in;     // latch the accepted request, restart the walk
    logic cnt_clr;
    logic cnt_dec;
    logic sub_do;     // check and append a subscription
    logic rd_last;    // read the last live entry instead of the walk index
    logic idx_inc;
    logic rem_inc;
    logic hit_take;   // park the current entry as pending delivery
    logic mv_write;   // copy read entry into the hole at the walk index
    logic emit_pend;
    logic emit_last;
    logic emit_final;
  } esm_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       idx_lt_cnt;
    logic       idx_next_lt_cnt;
    logic       at_cap;
    logic       pub_hit;
    logic       unsub_hit;
    logic       pend_valid;
    logic       out_free;
  } esm_sts_t;

endpackage

// ===== hdl/event_subscription_matcher.sv =====
// Channel  Dir  Handshake                Payload
// in       in   in_valid_i / in_stall_o  kind, key, bits, callback_handle, context_handle, payload
// out      out  out_valid_o / out_stall_i status, is_delivery, out_callback, out_context, out_key,
//                                        out_event, out_payload, removed_count, entry_total, last
//
// One request at a time; the table sits in a single-port-read RAM.
// Publish and unsubscribe walk the table entry by entry; an unsubscribe hit moves the last live
// entry into the hole unless the hit was itself the last. Subscribe and clear do not walk.
// Reset empties the table (entry count to zero); no clearing pass.
// A result held by out_stall_i does not block the next input transfer; the walk waits only
// when it has another result to load.
`include "assert_macros.svh"

module event_subscription_matcher #(
  parameter int MAX_ENTRIES = esm_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  key_i,
  input  logic [31:0] bits_i,
  input  logic [31:0] callback_handle_i,
  input  logic [31:0] context_handle_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        is_delivery_o,
  output logic [31:0] out_callback_o,
  output logic [31:0] out_context_o,
  output logic [3:0]  out_key_o,
  output logic [31:0] out_event_o,
  output logic [31:0] out_payload_o,
  output logic [5:0]  removed_count_o,
  output logic [5:0]  entry_total_o,
  output logic        last_o
);
  import esm_pkg::*;

  esm_cmd_t cmd;
  esm_sts_t sts;

  esm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .kind_i    (kind_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  esm_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .key_i            (key_i),
    .bits_i           (bits_i),
    .callback_handle_i(callback_handle_i),
    .context_handle_i (context_handle_i),
    .payload_i        (payload_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .is_delivery_o    (is_delivery_o),
    .out_callback_o   (out_callback_o),
    .out_context_o    (out_context_o),
    .out_key_o        (out_key_o),
    .out_event_o      (out_event_o),
    .out_payload_o    (out_payload_o),
    .removed_count_o  (removed_count_o),
    .entry_total_o    (entry_total_o),
    .last_o           (last_o)
  );

  `ESM_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit_pend || cmd.emit_final, sts.out_free)
  `ESM_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ESM_ASSERT_IMP(a_deliv_status, clk_i, rst_ni, out_valid_o && is_delivery_o, status_o == ST_DELIVERY)
  `ESM_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_o && !is_delivery_o, last_o)

endmodule

// ===== hdl/esm_ram.sv =====
module esm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/esm_ctrl.sv =====
module esm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        kind_i,
  output logic              in_stall_o,
  input  esm_pkg::esm_sts_t sts_i,
  output esm_pkg::esm_cmd_t cmd_o
);
  import esm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MV   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       is_pub;

  assign is_pub     = (sts_i.kind == KIND_PUB);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (kind_i == KIND_SUB) begin
            state_d = S_SUB;
          end else if (kind_i == KIND_CLR) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_FIN;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_SUB: begin
        cmd_o.sub_do = 1'b1;
        state_d      = S_FIN;
      end
      S_RD: begin
        if (sts_i.idx_lt_cnt && !(is_pub && sts_i.at_cap)) begin
          state_d = S_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CMP: begin
        if (is_pub) begin
          if (!sts_i.pub_hit) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end else if (!sts_i.pend_valid) begin
            cmd_o.hit_take = 1'b1;
            cmd_o.idx_inc  = 1'b1;
            state_d        = S_RD;
          end else if (sts_i.out_free) begin
            cmd_o.emit_pend = 1'b1;
            cmd_o.hit_take  = 1'b1;
            cmd_o.idx_inc   = 1'b1;
            state_d         = S_RD;
          end
        end else if (sts_i.unsub_hit) begin
          cmd_o.rem_inc = 1'b1;
          if (sts_i.idx_next_lt_cnt) begin
            cmd_o.rd_last = 1'b1;
            state_d       = S_MV;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_RD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_MV: begin
        cmd_o.mv_write = 1'b1;
        cmd_o.cnt_dec  = 1'b1;
        state_d        = S_RD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          if (sts_i.pend_valid) begin
            cmd_o.emit_pend = 1'b1;
            cmd_o.emit_last = 1'b1;
          end else begin
            cmd_o.emit_final = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/esm_dp.sv =====
module esm_dp #(
  parameter int MAX_ENTRIES = esm_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        kind_i,
  input  logic [3:0]        key_i,
  input  logic [31:0]       bits_i,
  input  logic [31:0]       callback_handle_i,
  input  logic [31:0]       context_handle_i,
  input  logic [31:0]       payload_i,
  input  esm_pkg::esm_cmd_t cmd_i,
  output esm_pkg::esm_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic              is_delivery_o,
  output logic [31:0]       out_callback_o,
  output logic [31:0]       out_context_o,
  output logic [3:0]        out_key_o,
  output logic [31:0]       out_event_o,
  output logic [31:0]       out_payload_o,
  output logic [5:0]        removed_count_o,
  output logic [5:0]        entry_total_o,
  output logic              last_o
);
  import esm_pkg::*;

  localparam int         IdxW     = $clog2(MAX_ENTRIES);
  localparam int         CntW     = $clog2(MAX_ENTRIES + 1);
  localparam int         EntryW   = $bits(esm_entry_t);
  localparam logic [8:0] KeyLimit = 9'(KEY_COUNT);

  logic [1:0]       kind_q;
  logic [3:0]       key_q;
  logic [31:0]      bits_q, cb_q, ctx_q, pay_q;
  logic [CntW-1:0]  idx_q, cnt_q, rem_q;
  logic [CntW-1:0]  last_idx;
  logic [CntW:0]    idx_next;
  logic [HIT_W-1:0] hits_q;
  logic [2:0]       sub_st_q, sub_st_d;
  logic             sub_ok;
  logic             pend_v_q;
  esm_entry_t       pend_q, rd_ent, new_ent;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  logic [CntW+5:0]   cnt_ext, rem_ext;

  logic        out_valid_q, out_deliv_q, out_last_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_cb_q, out_ctx_q, out_ev_q, out_pay_q;
  logic [3:0]  out_key_q;
  logic [5:0]  out_rem_q, out_tot_q;

  assign last_idx = cnt_q - CntW'(1);
  assign idx_next = {1'b0, idx_q} + (CntW + 1)'(1);

  assign rd_ent    = esm_entry_t'(ram_rdata);
  assign new_ent   = '{key: key_q, mask: bits_q, callback: cb_q, context_w: ctx_q};
  assign ram_raddr = cmd_i.rd_last ? last_idx[IdxW-1:0] : idx_q[IdxW-1:0];
  assign ram_we    = cmd_i.mv_write || (cmd_i.sub_do && sub_ok);
  assign ram_waddr = cmd_i.mv_write ? idx_q[IdxW-1:0] : cnt_q[IdxW-1:0];
  assign ram_wdata = cmd_i.mv_write ? ram_rdata : EntryW'(new_ent);

  esm_ram #(
    .WIDTH(EntryW),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    sub_ok = 1'b0;
    if (cb_q == 32'd0) begin
      sub_st_d = ST_NULL;
    end else if ({5'd0, key_q} >= KeyLimit) begin
      sub_st_d = ST_RANGE;
    end else if (cnt_q == CntW'(MAX_ENTRIES)) begin
      sub_st_d = ST_FULL;
    end else begin
      sub_st_d = ST_OK;
      sub_ok   = 1'b1;
    end
  end

  assign sts_o.kind            = kind_q;
  assign sts_o.idx_lt_cnt      = (idx_q < cnt_q);
  assign sts_o.idx_next_lt_cnt = (idx_next < {1'b0, cnt_q});
  assign sts_o.at_cap          = (hits_q == HIT_W'(MAX_RESULTS));
  assign sts_o.pub_hit         = (rd_ent.key == key_q) &&
                                 ((rd_ent.mask == 32'd0) || ((rd_ent.mask & bits_q) != 32'd0));
  assign sts_o.unsub_hit       = (rd_ent == new_ent);
  assign sts_o.pend_valid      = pend_v_q;
  assign sts_o.out_free        = !out_valid_q || !out_stall_i;

  // low six bits of the counters for the narrow result fields
  assign cnt_ext = {6'd0, cnt_q};
  assign rem_ext = {6'd0, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      hits_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.sub_do && sub_ok) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CntW'(1);
      end

      if (cmd_i.cap_in) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_next[CntW-1:0];
      end

      if (cmd_i.cap_in) begin
        rem_q <= '0;
      end else if (cmd_i.rem_inc) begin
        rem_q <= rem_q + CntW'(1);
      end

      if (cmd_i.cap_in) begin
        hits_q   <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.hit_take) begin
        hits_q   <= hits_q + HIT_W'(1);
        pend_v_q <= 1'b1;
      end

      if (cmd_i.emit_pend || cmd_i.emit_final) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      bits_q <= bits_i;
      cb_q   <= callback_handle_i;
      ctx_q  <= context_handle_i;
      pay_q  <= payload_i;
    end
    if (cmd_i.sub_do) begin
      sub_st_q <= sub_st_d;
    end
    if (cmd_i.hit_take) begin
      pend_q <= rd_ent;
    end
    if (cmd_i.emit_pend) begin
      out_status_q <= ST_DELIVERY;
      out_deliv_q  <= 1'b1;
      out_cb_q     <= pend_q.callback;
      out_ctx_q    <= pend_q.context_w;
      out_key_q    <= pend_q.key;
      out_ev_q     <= bits_q;
      out_pay_q    <= pay_q;
      out_rem_q    <= 6'd0;
      out_tot_q    <= cnt_ext[5:0];
      out_last_q   <= cmd_i.emit_last;
    end else if (cmd_i.emit_final) begin
      if (kind_q == KIND_SUB) begin
        out_status_q <= sub_st_q;
      end else if (kind_q == KIND_UNSUB) begin
        out_status_q <= (rem_q != '0) ? ST_OK : ST_NOT_FOUND;
      end else begin
        out_status_q <= ST_OK;
      end
      out_deliv_q <= 1'b0;
      out_cb_q    <= 32'd0;
      out_ctx_q   <= 32'd0;
      out_key_q   <= 4'd0;
      out_ev_q    <= 32'd0;
      out_pay_q   <= 32'd0;
      out_rem_q   <= rem_ext[5:0];
      out_tot_q   <= cnt_ext[5:0];
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign is_delivery_o   = out_deliv_q;
  assign out_callback_o  = out_cb_q;
  assign out_context_o   = out_ctx_q;
  assign out_key_o       = out_key_q;
  assign out_event_o     = out_ev_q;
  assign out_payload_o   = out_pay_q;
  assign removed_count_o = out_rem_q;
  assign entry_total_o   = out_tot_q;
  assign last_o          = out_last_q;

endmodule
